/* src/i2cseq_pkg.sv */
package i2cseq_pkg;

  // Sequence phases of one write-then-read transaction.
  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_ADDR1   = 4'd1,
    PH_ADDR2   = 4'd2,
    PH_WDATA   = 4'd3,
    PH_WSTOP   = 4'd4,
    PH_RESTART = 4'd5,
    PH_RADDR   = 4'd6,
    PH_RACK    = 4'd7,
    PH_RDATA   = 4'd8,
    PH_RDACK   = 4'd9
  } phase_e;

  // Commands handed to the bus engine.
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_RCEN    = 3'd3,
    CMD_ACK     = 3'd4,
    CMD_NACK    = 3'd5,
    CMD_STOP    = 3'd6
  } bus_cmd_e;

  // How many bytes a step takes off the head of the command queue.
  typedef enum logic [1:0] {
    PULL_NONE   = 2'd0,
    PULL_HEADER = 2'd1,
    PULL_ONE    = 2'd2,
    PULL_FLUSH  = 2'd3
  } pull_e;

  // Operation codes of an input word.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // Upper five bits of the first address byte that mark a 10-bit address.
  localparam logic [4:0] TEN_BIT_MARK = 5'b11110;
  localparam logic [7:0] ERROR_BYTE   = 8'hFF;
  localparam logic [7:0] WRITE_DONE   = 8'h00;
  localparam int unsigned HEADER_LEN  = 4;

  typedef struct packed {
    logic       operation;
    logic [7:0] push_byte;
    logic       ack_failed;
    logic [7:0] received_byte;
  } in_word_t;

  typedef struct packed {
    bus_cmd_e   bus_command;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       message_done;
    logic [7:0] freed_bytes;
    logic       queue_not_empty;
  } out_word_t;

  // Transaction state kept next to the command queue.
  typedef struct packed {
    phase_e     phase;
    logic [7:0] address_low;
    logic [7:0] address_high;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [7:0] bytes_left;
  } seq_state_t;

  // Bus-facing part of the result of one event.
  typedef struct packed {
    bus_cmd_e   bus_command;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       message_done;
  } step_res_t;

endpackage

/* src/i2cseq_step.sv */
module i2cseq_step import i2cseq_pkg::*; (
  input  seq_state_t      state_i,
  input  logic            ack_failed_i,
  input  logic [7:0]      received_byte_i,
  input  logic [3:0][7:0] header_i,
  input  logic [7:0]      data_byte_i,
  input  logic            header_ready_i,
  input  logic            queue_nz_i,
  output seq_state_t      state_o,
  output step_res_t       res_o,
  output pull_e           pull_o
);

  logic       fail;
  logic       finish;
  logic       header_go;
  logic       wdata_go;
  logic [7:0] left_dec;

  // Decode the conditions shared by the next-state and output logic.
  always_comb begin
    left_dec  = state_i.bytes_left - 8'd1;
    header_go = (state_i.phase == PH_START) && header_ready_i;
    wdata_go  = (state_i.phase == PH_WDATA) && !ack_failed_i && queue_nz_i;
    fail      = ack_failed_i && ((state_i.phase == PH_ADDR2) || (state_i.phase == PH_WDATA) ||
                                 (state_i.phase == PH_WSTOP) || (state_i.phase == PH_RACK));
    finish    = fail || (state_i.phase == PH_WSTOP) ||
                ((state_i.phase == PH_RACK) && (state_i.read_count == 8'd0)) ||
                ((state_i.phase == PH_RDACK) && (left_dec == 8'd0));
  end

  // Next phase and counters.
  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      PH_START: begin
        if (header_go) begin
          state_o.address_low  = header_i[0];
          state_o.address_high = header_i[1];
          state_o.write_count  = header_i[2];
          state_o.read_count   = header_i[3];
          state_o.bytes_left   = header_i[2];
          state_o.phase        = (header_i[2] != 8'd0) ? PH_ADDR1 : PH_RADDR;
        end
      end
      PH_ADDR1: begin
        state_o.phase = (state_i.address_low[7:3] == TEN_BIT_MARK) ? PH_ADDR2 : PH_WDATA;
      end
      PH_ADDR2: state_o.phase = PH_WDATA;
      PH_WDATA: begin
        if (wdata_go) begin
          state_o.bytes_left = left_dec;
          if (left_dec == 8'd0) begin
            state_o.phase = (state_i.read_count != 8'd0) ? PH_RESTART : PH_WSTOP;
          end
        end
      end
      PH_WSTOP:   state_o.phase = PH_WSTOP;
      PH_RESTART: state_o.phase = PH_RADDR;
      PH_RADDR:   state_o.phase = PH_RACK;
      PH_RACK: begin
        if (!ack_failed_i && (state_i.read_count != 8'd0)) begin
          state_o.bytes_left = state_i.read_count;
          state_o.phase      = PH_RDATA;
        end
      end
      PH_RDATA: state_o.phase = PH_RDACK;
      PH_RDACK: begin
        state_o.bytes_left = left_dec;
        state_o.phase      = PH_RDATA;
      end
      default: state_o.phase = PH_START;
    endcase
    if (finish) begin
      state_o.phase = PH_START;
    end
  end

  // Bus command, transmit and result bytes, queue consumption.
  always_comb begin
    res_o  = '0;
    pull_o = PULL_NONE;
    unique case (state_i.phase)
      PH_START: begin
        if (header_go) begin
          res_o.bus_command = CMD_START;
          pull_o            = PULL_HEADER;
        end
      end
      PH_ADDR1: begin
        res_o.tx_valid = 1'b1;
        res_o.tx_byte  = state_i.address_low;
      end
      PH_ADDR2: begin
        res_o.tx_valid = 1'b1;
        res_o.tx_byte  = state_i.address_high;
      end
      PH_WDATA: begin
        if (wdata_go) begin
          res_o.tx_valid = 1'b1;
          res_o.tx_byte  = data_byte_i;
          pull_o         = PULL_ONE;
        end
      end
      PH_WSTOP: begin
        res_o.rx_valid = 1'b1;
        res_o.rx_byte  = WRITE_DONE;
      end
      PH_RESTART: res_o.bus_command = CMD_RESTART;
      PH_RADDR: begin
        res_o.tx_valid = 1'b1;
        res_o.tx_byte  = state_i.address_low | 8'd1;
      end
      PH_RACK: begin
        res_o.rx_valid = 1'b1;
        res_o.rx_byte  = state_i.read_count;
        if (state_i.read_count != 8'd0) begin
          res_o.bus_command = CMD_RCEN;
        end
      end
      PH_RDATA: begin
        res_o.rx_valid    = 1'b1;
        res_o.rx_byte     = received_byte_i;
        res_o.bus_command = (state_i.bytes_left == 8'd1) ? CMD_NACK : CMD_ACK;
      end
      PH_RDACK: begin
        if (left_dec != 8'd0) begin
          res_o.bus_command = CMD_RCEN;
        end
      end
      default: res_o = '0;
    endcase
    // A missing acknowledge drops the rest of the command and reports an error.
    if (fail) begin
      res_o.tx_valid = 1'b0;
      res_o.tx_byte  = 8'd0;
      res_o.rx_valid = 1'b1;
      res_o.rx_byte  = ERROR_BYTE;
      pull_o         = PULL_FLUSH;
    end
    if (finish) begin
      res_o.message_done = 1'b1;
      res_o.bus_command  = CMD_STOP;
    end
  end

endmodule

/* src/i2c_master_transaction_sequencer_core.sv */
// I2C master write-then-read transaction sequencer.
//
// Input words arrive on in_valid_i / in_stall_o / in_word_i. A word either pushes
// one command byte into the command queue or reports that the bus engine finished
// its last operation. Every accepted word yields exactly one result word on
// out_valid_o / out_stall_i / out_word_o, in order.
//
// A word is accepted into an execute stage, which reads the queue memory (a
// registered read) and updates the sequence state; the result lands in an
// output register that drives out_valid_o. Words are taken back to back, one
// per cycle, while the receiver does not stall. The one exception is a bus
// event that loads a command header: it holds the execute stage while the
// header bytes are read, one queue memory read per header byte, since the
// memory has a single read port.
//
// Reset empties the queue and returns the sequence to the start phase; the
// memory contents are not cleared. When the receiver stalls, the result stays in
// the output register and the execute stage keeps its word, so in_stall_o rises
// once both are occupied. No word is lost or repeated.
module i2c_master_transaction_sequencer_core import i2cseq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW = (FW > 8) ? FW : 8;

  // Modular add of an offset of at most the depth to a queue index.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [7:0]      mem [QUEUE_DEPTH];
  logic [7:0]      mem_rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;

  logic            fwd_q, fwd_d;
  logic [7:0]      fwd_byte_q;

  seq_state_t      seq_q, seq_d;
  logic [AW-1:0]   head_q, head_d;
  logic [FW-1:0]   fill_q, fill_d;

  logic            b_valid_q, b_valid_d;
  in_word_t        b_item_q;
  logic [1:0]      ld_cnt_q, ld_cnt_d;
  logic [2:0][7:0] hdr_q;

  logic            out_valid_q, out_valid_d;
  out_word_t       out_q;

  logic            accept;
  logic            is_event;
  logic            out_free;
  logic            loading;
  logic            b_fire;
  logic [7:0]      b_byte;
  logic [3:0][7:0] header;

  seq_state_t      step_state;
  step_res_t       step_res;
  pull_e           step_pull;

  logic [MW-1:0]   left_ext;
  logic [MW-1:0]   fill_ext;
  logic [MW-1:0]   adv;

  // Queue byte seen by the execute stage, with a just-written byte forwarded.
  assign b_byte = fwd_q ? fwd_byte_q : mem_rd_q;
  assign header = {b_byte, hdr_q[2], hdr_q[1], hdr_q[0]};

  // Execute stage control.
  assign is_event   = (b_item_q.operation == OP_EVENT);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign loading    = b_valid_q && is_event && (seq_q.phase == PH_START) &&
                      (fill_q >= FW'(HEADER_LEN)) && (ld_cnt_q != 2'd3);
  assign b_fire     = b_valid_q && !loading && out_free;
  assign in_stall_o = b_valid_q && !b_fire;
  assign accept     = in_valid_i && !in_stall_o;

  i2cseq_step u_step (
    .state_i         (seq_q),
    .ack_failed_i    (b_item_q.ack_failed),
    .received_byte_i (b_item_q.received_byte),
    .header_i        (header),
    .data_byte_i     (b_byte),
    .header_ready_i  (fill_q >= FW'(HEADER_LEN)),
    .queue_nz_i      (fill_q != '0),
    .state_o         (step_state),
    .res_o           (step_res),
    .pull_o          (step_pull)
  );

  // Bytes taken off the queue head by this step.
  always_comb begin
    left_ext = MW'(seq_q.bytes_left);
    fill_ext = MW'(fill_q);
    unique case (step_pull)
      PULL_HEADER: adv = MW'(HEADER_LEN);
      PULL_ONE:    adv = MW'(1);
      PULL_FLUSH:  adv = (left_ext < fill_ext) ? left_ext : fill_ext;
      default:     adv = '0;
    endcase
  end

  // Queue pointers and sequence state.
  always_comb begin
    seq_d     = seq_q;
    head_d    = head_q;
    fill_d    = fill_q;
    mem_we    = 1'b0;
    mem_waddr = wrap_add(head_q, (AW+1)'(fill_q));
    if (b_fire) begin
      if (is_event) begin
        seq_d  = step_state;
        head_d = wrap_add(head_q, (AW+1)'(adv));
        fill_d = fill_q - FW'(adv);
      end else if (fill_q < FW'(QUEUE_DEPTH)) begin
        mem_we = 1'b1;
        fill_d = fill_q + FW'(1);
      end
    end
  end

  // Read address: next header byte, the held byte, or the new head.
  always_comb begin
    priority if (loading) begin
      mem_raddr = wrap_add(head_q, (AW+1)'(ld_cnt_q) + (AW+1)'(1));
    end else if (b_valid_q && !b_fire) begin
      mem_raddr = wrap_add(head_q, (AW+1)'(ld_cnt_q));
    end else begin
      mem_raddr = head_d;
    end
    fwd_d = mem_we && (mem_waddr == mem_raddr);
  end

  // Stage and output valid flags, header byte counter.
  always_comb begin
    b_valid_d   = accept ? 1'b1 : (b_fire ? 1'b0 : b_valid_q);
    ld_cnt_d    = loading ? ld_cnt_q + 2'd1 : (b_fire ? 2'd0 : ld_cnt_q);
    out_valid_d = b_fire ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  // Command queue memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= b_item_q.push_byte;
    end
    mem_rd_q <= mem[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '{phase: PH_START, default: '0};
      head_q      <= '0;
      fill_q      <= '0;
      b_valid_q   <= 1'b0;
      ld_cnt_q    <= 2'd0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      b_valid_q   <= b_valid_d;
      ld_cnt_q    <= ld_cnt_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    fwd_byte_q <= b_item_q.push_byte;
    if (accept) begin
      b_item_q <= in_word_i;
    end
    if (loading) begin
      hdr_q[ld_cnt_q] <= b_byte;
    end
    if (b_fire) begin
      if (is_event) begin
        out_q.bus_command  <= step_res.bus_command;
        out_q.tx_valid     <= step_res.tx_valid;
        out_q.tx_byte      <= step_res.tx_byte;
        out_q.rx_valid     <= step_res.rx_valid;
        out_q.rx_byte      <= step_res.rx_byte;
        out_q.message_done <= step_res.message_done;
        out_q.freed_bytes  <= adv[7:0];
      end else begin
        out_q.bus_command  <= CMD_NONE;
        out_q.tx_valid     <= 1'b0;
        out_q.tx_byte      <= 8'd0;
        out_q.rx_valid     <= 1'b0;
        out_q.rx_byte      <= 8'd0;
        out_q.message_done <= 1'b0;
        out_q.freed_bytes  <= 8'd0;
      end
      out_q.queue_not_empty <= (fill_d != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* bench/tb_i2c_master_transaction_sequencer_core.sv */
module tb_i2c_master_transaction_sequencer_core;
  import i2cseq_pkg::*;

  localparam int unsigned QDEPTH       = 256;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  i2c_master_transaction_sequencer_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Predicted sequencer state: command queue and transaction registers.
  logic [7:0] queued_bytes [QDEPTH];
  logic [7:0] q_head;
  logic [8:0] q_fill;
  phase_e     seq_phase;
  logic [7:0] addr_low, addr_high, write_cnt, read_cnt, bytes_left;

  out_word_t   awaited_results [$];
  logic [7:0]  planned_bytes [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned effective_words;
  int unsigned event_words;
  int unsigned finished_msgs;
  int unsigned failed_msgs;
  int unsigned dropped_pushes;
  int unsigned checked_words;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Clock with a period of 10 time units.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls at random, changing its stall at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i = rst_ni && ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic logic [7:0] take_queued_byte();
    take_queued_byte = queued_bytes[q_head];
    q_head = q_head + 8'd1;
    q_fill = q_fill - 9'd1;
  endfunction

  // Works out the result word of one accepted input word and advances the state.
  task automatic predict_sequencer_step(input in_word_t w, output out_word_t r,
                                        output logic moved);
    logic       fail;
    logic       finish;
    logic [8:0] n;
    logic [7:0] slot;
    r      = '0;
    fail   = 1'b0;
    finish = 1'b0;
    moved  = 1'b0;
    if (w.operation == OP_PUSH) begin
      if (q_fill < QDEPTH) begin
        slot = q_head + q_fill[7:0];
        queued_bytes[slot] = w.push_byte;
        q_fill = q_fill + 9'd1;
        moved = 1'b1;
      end else begin
        dropped_pushes++;
      end
    end else begin
      case (seq_phase)
        PH_START: begin
          // An event before the whole header is queued is ignored.
          if (q_fill >= HEADER_LEN) begin
            addr_low  = take_queued_byte();
            addr_high = take_queued_byte();
            write_cnt = take_queued_byte();
            read_cnt  = take_queued_byte();
            r.freed_bytes = 8'(HEADER_LEN);
            bytes_left = write_cnt;
            r.bus_command = CMD_START;
            seq_phase = (bytes_left != 8'd0) ? PH_ADDR1 : PH_RADDR;
          end
        end
        PH_ADDR1: begin
          r.tx_valid = 1'b1;
          r.tx_byte  = addr_low;
          seq_phase  = (addr_low[7:3] == TEN_BIT_MARK) ? PH_ADDR2 : PH_WDATA;
        end
        PH_ADDR2: begin
          if (w.ack_failed) begin
            fail = 1'b1;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte  = addr_high;
            seq_phase  = PH_WDATA;
          end
        end
        PH_WDATA: begin
          // With the next data byte not yet queued, an acknowledged event is ignored.
          if (w.ack_failed) begin
            fail = 1'b1;
          end else if (q_fill != 9'd0) begin
            r.tx_valid    = 1'b1;
            r.tx_byte     = take_queued_byte();
            r.freed_bytes = 8'd1;
            bytes_left    = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
              seq_phase = (read_cnt != 8'd0) ? PH_RESTART : PH_WSTOP;
            end
          end
        end
        PH_WSTOP: begin
          if (w.ack_failed) begin
            fail = 1'b1;
          end else begin
            r.rx_valid = 1'b1;
            r.rx_byte  = WRITE_DONE;
            finish     = 1'b1;
          end
        end
        PH_RESTART: begin
          r.bus_command = CMD_RESTART;
          seq_phase     = PH_RADDR;
        end
        PH_RADDR: begin
          r.tx_valid = 1'b1;
          r.tx_byte  = addr_low | 8'h01;
          seq_phase  = PH_RACK;
        end
        PH_RACK: begin
          if (w.ack_failed) begin
            fail = 1'b1;
          end else begin
            r.rx_valid = 1'b1;
            r.rx_byte  = read_cnt;
            if (read_cnt == 8'd0) begin
              finish = 1'b1;
            end else begin
              bytes_left    = read_cnt;
              r.bus_command = CMD_RCEN;
              seq_phase     = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          r.rx_valid    = 1'b1;
          r.rx_byte     = w.received_byte;
          r.bus_command = (bytes_left == 8'd1) ? CMD_NACK : CMD_ACK;
          seq_phase     = PH_RDACK;
        end
        PH_RDACK: begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) begin
            finish = 1'b1;
          end else begin
            r.bus_command = CMD_RCEN;
            seq_phase     = PH_RDATA;
          end
        end
        default: begin
          seq_phase = PH_START;
        end
      endcase
      // A missing acknowledge discards the rest of the write data that is queued.
      if (fail) begin
        n = ({1'b0, bytes_left} < q_fill) ? {1'b0, bytes_left} : q_fill;
        q_head = q_head + n[7:0];
        q_fill = q_fill - n;
        r.freed_bytes = n[7:0];
        r.rx_valid = 1'b1;
        r.rx_byte  = ERROR_BYTE;
        finish = 1'b1;
        failed_msgs++;
      end
      if (finish) begin
        r.message_done = 1'b1;
        r.bus_command  = CMD_STOP;
        seq_phase      = PH_START;
        finished_msgs++;
      end
      moved = (r.bus_command != CMD_NONE) || r.tx_valid || r.rx_valid ||
              (r.freed_bytes != 8'd0);
    end
    r.queue_not_empty = (q_fill != 9'd0);
  endtask

  // Offers one word, holds it until accepted and records its expected result.
  // Starts and ends at a falling edge.
  task automatic send_word(input in_word_t w);
    out_word_t  r;
    logic       moved;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_sequencer_step(w, r, moved);
    awaited_results.push_back(r);
    if (moved) effective_words++;
    if (w.operation == OP_EVENT) event_words++;
    @(negedge clk_i);
  endtask

  task automatic push_command_byte(input logic [7:0] b);
    in_word_t w;
    w.operation     = OP_PUSH;
    w.push_byte     = b;
    w.ack_failed    = 1'($urandom);
    w.received_byte = 8'($urandom);
    send_word(w);
  endtask

  task automatic signal_bus_done(input logic nak, input logic [7:0] rcv);
    in_word_t w;
    w.operation     = OP_EVENT;
    w.push_byte     = 8'($urandom);
    w.ack_failed    = nak;
    w.received_byte = rcv;
    send_word(w);
  endtask

  // Queues the bytes of one well-formed command for later pushing.
  function automatic void plan_command(input logic [7:0] a1, input logic [7:0] a2,
                                       input int unsigned wc, input int unsigned rc);
    planned_bytes.push_back(a1);
    planned_bytes.push_back(a2);
    planned_bytes.push_back(8'(wc));
    planned_bytes.push_back(8'(rc));
    repeat (wc) planned_bytes.push_back(8'($urandom));
  endfunction

  // Mostly short commands, a few long ones, and now and then a stray byte.
  function automatic void plan_random_command();
    logic [7:0]  a1;
    int unsigned wc;
    int unsigned rc;
    a1 = ($urandom_range(0, 3) == 0) ? {TEN_BIT_MARK, 3'($urandom)} : 8'($urandom);
    if ($urandom_range(0, 99) < 3) begin
      wc = $urandom_range(0, 255);
      rc = $urandom_range(0, 255);
    end else begin
      wc = $urandom_range(0, 6);
      rc = $urandom_range(0, 6);
    end
    plan_command(a1, 8'($urandom), wc, rc);
    if ($urandom_range(0, 99) < 3) planned_bytes.push_back(8'($urandom));
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    out_word_t want;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_results.size() == 0) begin
        $error("Result word arrived while no word was pending");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        checked_words++;
        compare_field("bus_command", 8'(want.bus_command), 8'(out_word_o.bus_command));
        compare_field("tx_valid", 8'(want.tx_valid), 8'(out_word_o.tx_valid));
        compare_field("tx_byte", want.tx_byte, out_word_o.tx_byte);
        compare_field("rx_valid", 8'(want.rx_valid), 8'(out_word_o.rx_valid));
        compare_field("rx_byte", want.rx_byte, out_word_o.rx_byte);
        compare_field("message_done", 8'(want.message_done),
                      8'(out_word_o.message_done));
        compare_field("freed_bytes", want.freed_bytes, out_word_o.freed_bytes);
        compare_field("queue_not_empty", 8'(want.queue_not_empty),
                      8'(out_word_o.queue_not_empty));
      end
    end
  end

  // Incomplete header, 10-bit address, write data arriving late, write-only end.
  task automatic test_header_wait_and_ten_bit_write();
    signal_bus_done(1'b0, 8'h00);
    push_command_byte(8'hF6);
    push_command_byte(8'hFF);
    push_command_byte(8'h01);
    signal_bus_done(1'b1, 8'hFF);
    push_command_byte(8'h00);
    signal_bus_done(1'b0, 8'h00);
    signal_bus_done(1'b1, 8'h00);
    signal_bus_done(1'b0, 8'hFF);
    signal_bus_done(1'b0, 8'h00);
    push_command_byte(8'h00);
    signal_bus_done(1'b0, 8'h00);
    signal_bus_done(1'b0, 8'hFF);
  endtask

  // A missing acknowledge on write data flushes the rest of the command.
  task automatic test_missing_ack_flush();
    push_command_byte(8'h00);
    push_command_byte(8'h00);
    push_command_byte(8'h02);
    push_command_byte(8'h03);
    push_command_byte(8'hFF);
    push_command_byte(8'h80);
    signal_bus_done(1'b0, 8'h00);
    signal_bus_done(1'b0, 8'h00);
    signal_bus_done(1'b1, 8'h00);
  endtask

  // Read-only command of one byte, closed with a nack and a stop.
  task automatic test_read_with_nack();
    push_command_byte(8'hFF);
    push_command_byte(8'h00);
    push_command_byte(8'h00);
    push_command_byte(8'h01);
    signal_bus_done(1'b0, 8'h00);
    signal_bus_done(1'b0, 8'h00);
    signal_bus_done(1'b0, 8'h00);
    signal_bus_done(1'b0, 8'hFF);
    signal_bus_done(1'b0, 8'h00);
  endtask

  // Fill the queue with four whole commands, push past the end, then drain.
  task automatic test_full_queue_drops();
    plan_command({TEN_BIT_MARK, 3'b101}, 8'h3C, 60, 0);
    repeat (3) plan_command(8'($urandom), 8'($urandom), 60, 0);
    planned_bytes.push_back(8'hA5);
    planned_bytes.push_back(8'h5A);
    while (planned_bytes.size() != 0) push_command_byte(planned_bytes.pop_front());
    while (q_fill != 9'd0 || seq_phase != PH_START) signal_bus_done(1'b0, 8'($urandom));
  endtask

  // Random commands, mostly well-formed, interleaved with bus events.
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned first;
    logic        header_ready;
    logic        do_push;
    first = effective_words;
    while (effective_words - first < n_words) begin
      if (planned_bytes.size() == 0) plan_random_command();
      header_ready = (seq_phase != PH_START) || (q_fill >= HEADER_LEN);
      if (!header_ready) begin
        do_push = ($urandom_range(0, 99) >= 5);
      end else begin
        do_push = (q_fill < 9'd192) && ($urandom_range(0, 99) < 40);
      end
      if (do_push) begin
        push_command_byte(planned_bytes.pop_front());
      end else begin
        signal_bus_done($urandom_range(0, 99) < 4, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_word_i       = '0;
    q_head          = '0;
    q_fill          = '0;
    seq_phase       = PH_START;
    addr_low        = '0;
    addr_high       = '0;
    write_cnt       = '0;
    read_cnt        = '0;
    bytes_left      = '0;
    effective_words = 0;
    event_words     = 0;
    finished_msgs   = 0;
    failed_msgs     = 0;
    dropped_pushes  = 0;
    send_idle_pct   = 27;
    recv_stall_pct  = 79;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_header_wait_and_ten_bit_write();
    test_missing_ack_flush();
    test_read_with_nack();
    test_full_queue_drops();
    test_random_traffic(380);

    send_idle_pct  = 79;
    recv_stall_pct = 27;
    test_random_traffic(380);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(380);

    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d effective words (%0d bus events), %0d transactions ended, %0d on a nack.",
             effective_words, event_words, finished_msgs, failed_msgs);
    $display("Checked %0d result words; %0d pushes fell on a full queue.",
             checked_words, dropped_pushes);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/i2cseq_pkg.sv
src/i2cseq_step.sv
src/i2c_master_transaction_sequencer_core.sv
bench/tb_i2c_master_transaction_sequencer_core.sv
